FILE: src/ct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ct_pkg;

	// Default width of an amino-acid id
	localparam int AMINO_ID_BITS_DEF = 5;

	// Codon table geometry: three bases of two bits each
	localparam int CODON_BITS  = 6;
	localparam int TABLE_DEPTH = 1 << CODON_BITS;

	// Command codes on the input channel
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEXT = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_AMINO   = 2'd0;
	localparam logic [1:0] KIND_UNKNOWN = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// Base codes
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	// Access request to the codon table
	typedef struct packed {
		logic                  wr;
		logic                  rd;
		logic [CODON_BITS-1:0] addr;
	} tbl_req_t;

endpackage

`default_nettype wire

FILE: src/codon_translator.sv
`timescale 1ns / 1ps
`default_nettype none

// codon_translator: DNA text to amino-acid ids.
// Input channel (in_valid/in_ready): command 0 loads one codon table entry,
// command 1 carries one text byte, with sequence_end on the last byte of a
// sequence. Whitespace is skipped, lower case folded, bases grouped in threes.
// Output channel (out_valid/out_ready): kind (amino, unknown, end), amino_id
// and last, which marks the end-of-sequence item.
// Throughput: one input item per cycle while the receiver keeps up. An item
// that yields two results (a codon closed by the last byte of a sequence)
// holds the input back until the first result leaves, since the output port moves one result per cycle.
// Result path: the accepting edge fills the stage-1 register and reads the
// table; the result register, which drives out_valid, is filled when the
// stage-1 item moves on, which a stalled receiver can hold back.
// Reset empties the codon table at once (per-entry valid flops), clears the
// frame, the halt flag and the loaded flag; no clearing pass is needed.
// When the receiver stalls, the result register holds, the stage-1 item
// waits behind it and in_ready drops; one pending result still lets a new
// item in if it leaves this cycle.
module codon_translator #(
	parameter int AMINO_ID_BITS = ct_pkg::AMINO_ID_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire                      command,
	input  wire [7:0]                text_byte,
	input  wire                      sequence_end,
	input  wire [5:0]                entry_codon,
	input  wire                      entry_valid,
	input  wire                      entry_stop,
	input  wire [AMINO_ID_BITS-1:0]  entry_amino,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [1:0]               kind,
	output logic [AMINO_ID_BITS-1:0] amino_id,
	output logic                     last
);

	// ---------------- frame state (advanced at accept) ----------------
	logic [3:0] held_q;
	logic [1:0] phase_q;
	logic       bad_q;
	logic       loaded_q;
	logic       halted_q;

	// ---------------- stage 1 ----------------
	logic s1_valid_q;
	logic codon_s1;
	logic bad_s1;
	logic end_s1;
	logic loaded_s1;

	// ---------------- result register ----------------
	// cnt_q counts pending results; a second pending one is always the end item
	logic [1:0]               cnt_q;
	logic [1:0]               kind_q;
	logic [AMINO_ID_BITS-1:0] amino_q;
	logic                     last_q;

	logic                     in_fire;
	logic                     is_text;
	logic                     blank;
	logic [7:0]               upper;
	logic [1:0]               base;
	logic                     base_ok;
	logic                     adv_base;
	logic                     codon_done;
	logic                     bad_now;
	ct_pkg::tbl_req_t         req;
	logic [AMINO_ID_BITS:0]   wr_data;
	logic                     tbl_valid;
	logic [AMINO_ID_BITS:0]   tbl_data;

	logic                     s2_free;
	logic                     s1_adv;
	logic                     out_fire;
	logic                     live_codon;
	logic                     codon_unknown;
	logic                     codon_stop;
	logic                     emit_codon;
	logic                     emit_end;
	logic                     halt_set;

	// ---------------- byte decode ----------------
	always_comb begin
		is_text = (command == ct_pkg::CMD_TEXT);
		blank   = (text_byte == 8'h20) || (text_byte >= 8'h09 && text_byte <= 8'h0D);
		upper   = (text_byte >= 8'h61 && text_byte <= 8'h7A) ? text_byte - 8'd32
		                                                      : text_byte;
		base    = ct_pkg::BASE_A;
		base_ok = 1'b1;
		unique case (upper)
			8'h41:   base = ct_pkg::BASE_A;
			8'h43:   base = ct_pkg::BASE_C;
			8'h47:   base = ct_pkg::BASE_G;
			8'h54:   base = ct_pkg::BASE_T;
			default: begin
				base    = ct_pkg::BASE_A;   // bad byte counts as a base, code zero
				base_ok = 1'b0;
			end
		endcase
		adv_base   = is_text && !blank;
		codon_done = adv_base && (phase_q == 2'd2);
		bad_now    = bad_q || !base_ok;
	end

	// ---------------- table access ----------------
	assign in_fire  = in_valid && in_ready;
	assign req.wr   = in_fire && !is_text;
	assign req.rd   = in_fire && codon_done;
	assign req.addr = is_text ? {held_q, base} : entry_codon;
	assign wr_data  = entry_valid ? {entry_stop, entry_amino} : '0;

	ct_table #(
		.AMINO_ID_BITS (AMINO_ID_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.wr_valid   (entry_valid),
		.wr_data    (wr_data),
		.rd_valid_q (tbl_valid),
		.rd_data_q  (tbl_data)
	);

	// ---------------- handshake ----------------
	assign out_fire = out_valid && out_ready;
	assign s2_free  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign s1_adv   = s1_valid_q && s2_free;
	assign in_ready = !s1_valid_q || s2_free;

	// ---------------- frame update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			phase_q  <= '0;
			bad_q    <= 1'b0;
			loaded_q <= 1'b0;
		end else if (in_fire) begin
			if (!is_text) begin
				if (entry_valid) begin
					loaded_q <= 1'b1;
				end
			end else if (sequence_end) begin
				held_q  <= '0;
				phase_q <= '0;
				bad_q   <= 1'b0;
			end else if (adv_base) begin
				if (codon_done) begin
					held_q  <= '0;
					phase_q <= '0;
					bad_q   <= 1'b0;
				end else begin
					held_q  <= {held_q[1:0], base};
					phase_q <= phase_q + 2'd1;
					bad_q   <= bad_now;
				end
			end
		end
	end

	// ---------------- stage 1 register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			codon_s1  <= codon_done;
			bad_s1    <= bad_now;
			end_s1    <= is_text && sequence_end;
			loaded_s1 <= loaded_q;
		end
	end

	// ---------------- result decision ----------------
	always_comb begin
		live_codon    = codon_s1 && loaded_s1 && !halted_q;
		codon_unknown = bad_s1 || !tbl_valid;
		codon_stop    = !codon_unknown && tbl_data[AMINO_ID_BITS];
		emit_codon    = live_codon && !codon_stop;
		halt_set      = live_codon && codon_stop;
		emit_end      = end_s1 && loaded_s1;
	end

	// halt lasts until the sequence closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (s1_adv) begin
			if (end_s1) begin
				halted_q <= 1'b0;
			end else if (halt_set) begin
				halted_q <= 1'b1;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s1_adv) begin
			cnt_q <= {1'b0, emit_codon} + {1'b0, emit_end};
		end else if (out_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (emit_codon) begin
				kind_q  <= codon_unknown ? ct_pkg::KIND_UNKNOWN : ct_pkg::KIND_AMINO;
				amino_q <= codon_unknown ? '0 : tbl_data[AMINO_ID_BITS-1:0];
				last_q  <= 1'b0;
			end else begin
				kind_q  <= ct_pkg::KIND_END;
				amino_q <= '0;
				last_q  <= 1'b1;
			end
		end else if (out_fire && cnt_q == 2'd2) begin
			kind_q  <= ct_pkg::KIND_END;
			amino_q <= '0;
			last_q  <= 1'b1;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign kind      = kind_q;
	assign amino_id  = amino_q;
	assign last      = last_q;

	// ---------------- assertions ----------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result count out of range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("frame phase out of range");

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind == ct_pkg::KIND_END)))
		else $error("last flag does not match end kind");

	a_amino_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != ct_pkg::KIND_AMINO) |-> (amino_id == '0))
		else $error("amino id set on a non-amino result");

	a_pair_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (last == 1'b0))
		else $error("two pending results but head is an end item");

endmodule

`default_nettype wire

FILE: src/ct_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Codon table: one access per cycle, registered read data.
// Entry valid bits live in flops so reset empties the table at once.
module ct_table #(
	parameter int AMINO_ID_BITS = ct_pkg::AMINO_ID_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  ct_pkg::tbl_req_t        req,
	input  wire                     wr_valid,
	input  wire [AMINO_ID_BITS:0]   wr_data,
	output logic                    rd_valid_q,
	output logic [AMINO_ID_BITS:0]  rd_data_q
);

	logic [ct_pkg::TABLE_DEPTH-1:0] vbits_q;
	logic [AMINO_ID_BITS:0]         mem_q [ct_pkg::TABLE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr) begin
				vbits_q[req.addr] <= wr_valid;
			end
			if (req.rd) begin
				rd_valid_q <= vbits_q[req.addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.addr] <= wr_data;
		end
		if (req.rd) begin
			rd_data_q <= mem_q[req.addr];
		end
	end

endmodule

`default_nettype wire

FILE: sim/codon_translator_tb.sv
`timescale 1ns / 1ps

module codon_translator_tb;

	localparam int AW = ct_pkg::AMINO_ID_BITS_DEF;

	// one result off the output channel
	typedef struct packed {
		logic [1:0]    kind;
		logic [AW-1:0] amino;
		logic          last;
	} aa_result_t;

	// Keeps its own copy of the codon table and reading frame, turns each
	// accepted item into the results it should cause and checks the block's
	// results against them in order.
	class codon_checker;
		logic          entry_ok [64];
		logic          entry_stp [64];
		logic [AW-1:0] entry_id [64];
		logic          any_loaded;
		logic [3:0]    held;
		int            held_cnt;
		logic          codon_bad;
		logic          stopped;
		aa_result_t    due_results [$];
		int            failures;

		function new();
			foreach (entry_ok[i]) begin
				entry_ok[i]  = 1'b0;
				entry_stp[i] = 1'b0;
				entry_id[i]  = '0;
			end
			any_loaded = 1'b0;
			held       = '0;
			held_cnt   = 0;
			codon_bad  = 1'b0;
			stopped    = 1'b0;
			failures   = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void queue_result(logic [1:0] k, logic [AW-1:0] a, logic l);
			aa_result_t r;
			r.kind  = k;
			r.amino = a;
			r.last  = l;
			due_results.insert(due_results.size(), r);
		endfunction

		function void reset_frame();
			held      = '0;
			held_cnt  = 0;
			codon_bad = 1'b0;
		endfunction

		function void take_item(logic cmd, logic [7:0] ch, logic fin, logic [5:0] cod,
			logic ok, logic stp, logic [AW-1:0] am);
			logic [7:0] up;
			logic [1:0] b;
			logic [5:0] idx;
			if (cmd == ct_pkg::CMD_LOAD) begin
				// an empty entry keeps neither stop nor id
				entry_ok[cod]  = ok;
				entry_stp[cod] = ok & stp;
				entry_id[cod]  = ok ? am : '0;
				if (ok)
					any_loaded = 1'b1;
			end else begin
				if (!(ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D))) begin
					up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
					b  = ct_pkg::BASE_A;
					case (up)
						"A": b = ct_pkg::BASE_A;
						"C": b = ct_pkg::BASE_C;
						"G": b = ct_pkg::BASE_G;
						"T": b = ct_pkg::BASE_T;
						default: codon_bad = 1'b1;
					endcase
					if (held_cnt < 2) begin
						held = {held[1:0], b};
						held_cnt++;
					end else begin
						idx = {held, b};
						if (any_loaded && !stopped) begin
							if (codon_bad || !entry_ok[idx])
								queue_result(ct_pkg::KIND_UNKNOWN, '0, 1'b0);
							else if (entry_stp[idx])
								stopped = 1'b1;
							else
								queue_result(ct_pkg::KIND_AMINO, entry_id[idx], 1'b0);
						end
						reset_frame();
					end
				end
				if (fin) begin
					if (any_loaded)
						queue_result(ct_pkg::KIND_END, '0, 1'b1);
					reset_frame();
					stopped = 1'b0;
				end
			end
		endfunction

		function void match_result(logic [1:0] k, logic [AW-1:0] a, logic l);
			aa_result_t want;
			if (due_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result kind=%0d amino=%0d last=%0b",
						$realtime, k, a, l);
			end else begin
				want = due_results.pop_front();
				if (k !== want.kind || a !== want.amino || l !== want.last) begin
					failures++;
					if (failures <= 10)
						$display({"%0t: result mismatch: kind exp %0d got %0d, ",
							"amino exp %0d got %0d, last exp %0b got %0b"}, $realtime,
							want.kind, k, want.amino, a, want.last, l);
				end
			end
		endfunction
	endclass

	// receiver behavior between hold-offs
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

	localparam int LATENCY_WAIT = 8;   // drain wait; results pass stage 1 and the result register
	localparam int HOLD_CYCLES  = 250; // long receiver hold-off
	localparam int RANDOM_ITEMS = 1250;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic          command;
	logic [7:0]    text_byte;
	logic          sequence_end;
	logic [5:0]    entry_codon;
	logic          entry_valid;
	logic          entry_stop;
	logic [AW-1:0] entry_amino;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [1:0]    kind;
	logic [AW-1:0] amino_id;
	logic          last;

	codon_checker book = new();

	// sender pacing
	int items_sent;
	int burst_left;
	bit no_gaps;

	// hold-off requests from the sender, served by the receiver process
	int       hold_asks;
	int       hold_done = 0;
	int       hold_left = 0;
	rx_mode_e rx_mode   = RX_OPEN;
	int       mode_left = 0;

	logic [7:0] base_chars [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
	logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	codon_translator #(
		.AMINO_ID_BITS(AW)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.text_byte   (text_byte),
		.sequence_end(sequence_end),
		.entry_codon (entry_codon),
		.entry_valid (entry_valid),
		.entry_stop  (entry_stop),
		.entry_amino (entry_amino),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.amino_id    (amino_id),
		.last        (last)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Monitors sample at the rising edge, before this edge's drive updates land.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			book.take_item(command, text_byte, sequence_end, entry_codon,
				entry_valid, entry_stop, entry_amino);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.match_result(kind, amino_id, last);
	end

	// Receiver: a long hold-off when the sender asks for one, otherwise a
	// stall pattern picked at random and picked anew when its run ends (always
	// ready, coin flip, mostly stalled, alternating).
	always @(posedge clk) begin
		if (hold_asks != hold_done) begin
			hold_done <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_e'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= mode_left[0];
			endcase
		end
	end

	// Offers one item and holds it until taken, then applies the burst/gap
	// pacing. Called at a rising edge; returns at a rising edge.
	task automatic put_item(input logic cmd, input logic [7:0] ch, input logic fin,
		input logic [5:0] cod, input logic ok, input logic stp, input logic [AW-1:0] am);
		int gap;
		command      <= cmd;
		text_byte    <= ch;
		sequence_end <= fin;
		entry_codon  <= cod;
		entry_valid  <= ok;
		entry_stop   <= stp;
		entry_amino  <= am;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0 && !no_gaps) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
	endtask

	// text item: table fields carry junk
	task automatic send_text(input logic [7:0] ch, input logic fin);
		put_item(ct_pkg::CMD_TEXT, ch, fin, 6'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			AW'($urandom_range(0, (1 << AW) - 1)));
	endtask

	// load item: text fields carry junk
	task automatic send_load(input logic [5:0] cod, input logic ok, input logic stp,
		input logic [AW-1:0] am);
		put_item(ct_pkg::CMD_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			cod, ok, stp, am);
	endtask

	// mostly filled, a few stops
	task automatic load_random_entry(input logic [5:0] cod);
		send_load(cod, $urandom_range(0, 5) != 0, $urandom_range(0, 11) == 0,
			AW'($urandom_range(0, (1 << AW) - 1)));
	endtask

	// A well-formed sequence: ncod codons of mixed-case bases with stray
	// whitespace and the odd junk byte, sometimes a partial codon at the tail;
	// closed either on the last base or on a trailing blank.
	task automatic send_sequence(input int ncod);
		int         nb;
		bit         close_on_base;
		logic [7:0] c;
		nb = ncod * 3 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
		close_on_base = (nb != 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < nb; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_text(blank_chars[$urandom_range(0, 5)], 1'b0);
			c = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255))
				: base_chars[$urandom_range(0, 7)];
			send_text(c, close_on_base && (i == nb - 1));
		end
		if (!close_on_base)
			send_text(blank_chars[$urandom_range(0, 5)], 1'b1);
	endtask

	// Stop offering and wait until every predicted result has come out, then
	// give the pipeline time to finish items that cause no result.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (book.pending() != 0);
		@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	initial begin
		int goal;
		bit held_off;
		bit drained;
		int n;

		// every input known from time zero
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = ct_pkg::CMD_TEXT;
		text_byte    = '0;
		sequence_end = 1'b0;
		entry_codon  = '0;
		entry_valid  = 1'b0;
		entry_stop   = 1'b0;
		entry_amino  = '0;
		items_sent   = 0;
		burst_left   = 1;
		no_gaps      = 1'b0;
		hold_asks    = 0;
		held_off     = 1'b0;
		drained      = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// empty table: a full sequence gives nothing, not even the end
		send_text("A", 1'b0);
		send_text("G", 1'b1);
		// ATG -> 0, TTT -> max id, TAA stop, GGG loaded empty with junk fields
		send_load({ct_pkg::BASE_A, ct_pkg::BASE_T, ct_pkg::BASE_G}, 1'b1, 1'b0, '0);
		send_load({ct_pkg::BASE_T, ct_pkg::BASE_T, ct_pkg::BASE_T}, 1'b1, 1'b0, '1);
		send_load({ct_pkg::BASE_T, ct_pkg::BASE_A, ct_pkg::BASE_A}, 1'b1, 1'b1, AW'(5));
		send_load({ct_pkg::BASE_G, ct_pkg::BASE_G, ct_pkg::BASE_G}, 1'b0, 1'b1, AW'(17));
		// lower case codon
		send_text("a", 1'b0);
		send_text("t", 1'b0);
		send_text("g", 1'b0);
		// blanks inside a codon are skipped
		send_text("T", 1'b0);
		send_text(8'h09, 1'b0);
		send_text("t", 1'b0);
		send_text("T", 1'b0);
		// empty entry -> unknown
		send_text("G", 1'b0);
		send_text("g", 1'b0);
		send_text("G", 1'b0);
		// zero byte and top-bit byte count as bad bases
		send_text(8'h00, 1'b0);
		send_text("A", 1'b0);
		send_text(8'hFF, 1'b0);
		// stop, then a codon swallowed while halted
		send_text("T", 1'b0);
		send_text("A", 1'b0);
		send_text("A", 1'b0);
		send_text("A", 1'b0);
		send_text("T", 1'b0);
		send_text("g", 1'b0);
		// partial codon dropped, end carried on a blank
		send_text("A", 1'b0);
		send_text(8'h20, 1'b1);
		// codon closed by the last byte: amino then end
		send_text("T", 1'b0);
		send_text("T", 1'b0);
		send_text("T", 1'b1);

		goal = items_sent + RANDOM_ITEMS;

		// --- random ---
		// wipe every entry: the table counts as loaded still, so all unknown
		for (int i = 0; i < 64; i++)
			send_load(6'(i), 1'b0, 1'($urandom_range(0, 1)),
				AW'($urandom_range(0, (1 << AW) - 1)));
		send_sequence(4);
		send_sequence(2);
		for (int i = 0; i < 64; i++)
			load_random_entry(6'(i));

		while (items_sent < goal) begin
			if (!held_off && items_sent > 500) begin
				// long receiver hold-off while a gapless sequence backs up the block
				held_off = 1'b1;
				hold_asks = hold_asks + 1;
				no_gaps = 1'b1;
				send_sequence(15);
				no_gaps = 1'b0;
			end else if (!drained && items_sent > 900) begin
				drained = 1'b1;
				wait_drained();
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						// broken stream: junk bytes, random ends
						n = $urandom_range(1, 6);
						repeat (n)
							send_text(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
					end
					1: begin
						n = $urandom_range(1, 4);
						repeat (n)
							load_random_entry(6'($urandom_range(0, 63)));
					end
					default: send_sequence($urandom_range(0, 10));
				endcase
			end
		end

		wait_drained();
		if (book.failures == 0 && book.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
